// ===== rtl/lwac_pkg.sv =====
package lwac_pkg;

    localparam int VALUE_W = 32;
    localparam int COURANT_W = 17;
    localparam int HALF_DT_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam int RAW_W = 42;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic [COURANT_W-1:0] COURANT_RESET = 17'd32768;
    localparam logic [HALF_DT_W-1:0] HALF_DT_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COURANT = 1'b0,
        CFG_HALF_DT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      clip;
    } t_sat;

    function automatic t_sat sat_value(input logic signed [RAW_W-1:0] x);
        t_sat res;
        if (x > RAW_W'(VAL_MAX)) begin
            res.value = VAL_MAX;
            res.clip = 1'b1;
        end else if (x < RAW_W'(VAL_MIN)) begin
            res.value = VAL_MIN;
            res.clip = 1'b1;
        end else begin
            res.value = x[VALUE_W-1:0];
            res.clip = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== rtl/lax_wendroff_acoustic_cell_update_unit.sv =====
// Lax-Wendroff acoustic cell update, one interior cell per transaction.
// Input channel: a transaction is taken at a rising clock edge where start
// is high and busy is low. busy is low whenever reset is released, so a new
// cell may be presented in every cycle. All twelve neighbourhood values come
// with the transaction as Q16.16 two's complement numbers.
// Output channel: o_valid is high for exactly one cycle per transaction, and
// the four updated values and the saturated flag are valid in that cycle.
// The receiver cannot stall, so results appear in the order of entry.
// Throughput is one cell per cycle. The pipeline depth is set by a chain of
// three dependent multiplications: the stencil products, the Courant
// scaling of the s update, and the half time step scaling of u.
// Configuration: i_cfg_we writes i_cfg_data into the register selected by
// i_cfg_idx (0 courant in Q1.16, 1 half time step in Q0.32) with no wait.
// Write it only while no transaction is in flight.
// Reset is synchronous and active low; it clears the pipeline valid bits
// and returns courant to 0.5 and the half time step to 0.
module lax_wendroff_acoustic_cell_update_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_r_here,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_r_east,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_r_west,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_l_here,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_l_north,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_l_south,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_s_here,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_s_east,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_s_west,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_s_north,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_s_south,
    input  logic signed [lwac_pkg::VALUE_W-1:0]   i_u_here,
    input  logic                                  i_cfg_we,
    input  logic [lwac_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lwac_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                  o_valid,
    output logic signed [lwac_pkg::VALUE_W-1:0]   o_r_next,
    output logic signed [lwac_pkg::VALUE_W-1:0]   o_l_next,
    output logic signed [lwac_pkg::VALUE_W-1:0]   o_s_next,
    output logic signed [lwac_pkg::VALUE_W-1:0]   o_u_next,
    output logic                                  o_saturated
);
    import lwac_pkg::*;

    logic                     accept;

    logic [COURANT_W-1:0]     r_courant;
    logic [HALF_DT_W-1:0]     r_half_dt;
    logic signed [17:0]       c_s;
    logic signed [17:0]       d_s;

    // Stage 1: differences.
    logic                     r_s1_v;
    logic signed [VALUE_W-1:0] r_s1_r, r_s1_l, r_s1_s, r_s1_u;
    logic signed [32:0]       r_s1_dse, r_s1_dsn;
    logic signed [34:0]       r_s1_r2, r_s1_l2, r_s1_hx;
    logic signed [35:0]       r_s1_s2;
    logic signed [32:0]       n_s1_dse, n_s1_dsn;
    logic signed [34:0]       n_s1_r2, n_s1_l2, n_s1_hx;
    logic signed [35:0]       n_s1_s2;

    // Stage 2: stencil products.
    logic                     r_s2_v;
    logic signed [VALUE_W-1:0] r_s2_r, r_s2_l, r_s2_s, r_s2_u;
    logic signed [50:0]       r_s2_pr1, r_s2_pl1;
    logic signed [52:0]       r_s2_pr2, r_s2_pl2;
    logic signed [34:0]       r_s2_hx;
    logic signed [53:0]       r_s2_ph;
    logic signed [50:0]       n_s2_pr1, n_s2_pl1;
    logic signed [52:0]       n_s2_pr2, n_s2_pl2;
    logic signed [53:0]       n_s2_ph;

    // Stage 3: sums and rounding.
    logic                     r_s3_v;
    logic signed [VALUE_W-1:0] r_s3_s, r_s3_u;
    logic signed [RAW_W-1:0]  r_s3_rraw, r_s3_lraw;
    logic signed [37:0]       r_s3_h;
    logic signed [53:0]       n_s3_racc, n_s3_lacc;
    logic signed [54:0]       n_s3_hacc;
    logic signed [RAW_W-1:0]  n_s3_rraw, n_s3_lraw;
    logic signed [37:0]       n_s3_h;

    // Stage 4: Courant scaling of h, clipping of r and l.
    logic                     r_s4_v;
    logic signed [VALUE_W-1:0] r_s4_s, r_s4_u, r_s4_rn, r_s4_ln;
    logic                     r_s4_clip;
    logic signed [55:0]       r_s4_ch;
    t_sat                     n_s4_rsat, n_s4_lsat;
    logic signed [55:0]       n_s4_ch;

    // Stage 5: s update and magnitude of its change.
    logic                     r_s5_v;
    logic signed [VALUE_W-1:0] r_s5_u, r_s5_rn, r_s5_ln, r_s5_sn;
    logic                     r_s5_clip, r_s5_neg;
    logic [VALUE_W-1:0]       r_s5_mag;
    logic signed [55:0]       n_s5_cacc;
    logic signed [RAW_W-1:0]  n_s5_sraw;
    t_sat                     n_s5_ssat;
    logic signed [32:0]       n_s5_delta, n_s5_abs;

    // Stage 6: half time step product.
    logic                     r_s6_v;
    logic signed [VALUE_W-1:0] r_s6_u, r_s6_rn, r_s6_ln, r_s6_sn;
    logic                     r_s6_clip, r_s6_neg;
    logic [63:0]              r_s6_prod;
    logic [63:0]              n_s6_prod;

    // Stage 7: u update, output registers.
    logic                     r_s7_v;
    logic signed [VALUE_W-1:0] r_s7_rn, r_s7_ln, r_s7_sn, r_s7_un;
    logic                     r_s7_clip;
    logic [63:0]              n_s7_pacc;
    logic [31:0]              n_s7_q;
    logic signed [RAW_W-1:0]  n_s7_qs, n_s7_uraw;
    t_sat                     n_s7_usat;

    assign busy = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_courant <= COURANT_RESET;
            r_half_dt <= HALF_DT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COURANT: r_courant <= i_cfg_data[COURANT_W-1:0];
                CFG_HALF_DT: r_half_dt <= i_cfg_data[HALF_DT_W-1:0];
                default: ;
            endcase
        end
    end

    assign c_s = $signed({1'b0, r_courant});
    assign d_s = 18'sd65536 - c_s;

    always_comb begin
        n_s1_dse = 33'(i_s_east) - 33'(i_s_west);
        n_s1_dsn = 33'(i_s_north) - 33'(i_s_south);
        n_s1_r2 = 35'(i_r_east) + 35'(i_r_west) - (35'(i_r_here) <<< 1);
        n_s1_l2 = 35'(i_l_north) + 35'(i_l_south) - (35'(i_l_here) <<< 1);
        n_s1_hx = 35'(i_r_east) - 35'(i_r_west) + 35'(i_l_north) - 35'(i_l_south);
        n_s1_s2 = 36'(i_s_east) + 36'(i_s_west) + 36'(i_s_north) + 36'(i_s_south)
                - (36'(i_s_here) <<< 2);
    end

    always_comb begin
        n_s2_pr1 = 51'(c_s) * 51'(r_s1_dse);
        n_s2_pl1 = 51'(c_s) * 51'(r_s1_dsn);
        n_s2_pr2 = 53'(d_s) * 53'(r_s1_r2);
        n_s2_pl2 = 53'(d_s) * 53'(r_s1_l2);
        n_s2_ph = 54'(d_s) * 54'(r_s1_s2);
    end

    always_comb begin
        n_s3_racc = 54'(r_s2_pr1) + 54'(r_s2_pr2) + 54'sd65536;
        n_s3_lacc = 54'(r_s2_pl1) + 54'(r_s2_pl2) + 54'sd65536;
        n_s3_hacc = (55'(r_s2_hx) <<< 16) + 55'(r_s2_ph) + 55'sd65536;
        n_s3_rraw = RAW_W'(r_s2_r) + RAW_W'($signed(n_s3_racc[53:17]));
        n_s3_lraw = RAW_W'(r_s2_l) + RAW_W'($signed(n_s3_lacc[53:17]));
        n_s3_h = $signed(n_s3_hacc[54:17]);
    end

    always_comb begin
        n_s4_rsat = sat_value(r_s3_rraw);
        n_s4_lsat = sat_value(r_s3_lraw);
        n_s4_ch = 56'(c_s) * 56'(r_s3_h);
    end

    always_comb begin
        n_s5_cacc = r_s4_ch + 56'sd32768;
        n_s5_sraw = RAW_W'(r_s4_s) + RAW_W'($signed(n_s5_cacc[55:16]));
        n_s5_ssat = sat_value(n_s5_sraw);
        n_s5_delta = 33'(n_s5_ssat.value) - 33'(r_s4_s);
        n_s5_abs = n_s5_delta[32] ? -n_s5_delta : n_s5_delta;
    end

    assign n_s6_prod = 64'(r_s5_mag) * 64'(r_half_dt);

    always_comb begin
        n_s7_pacc = r_s6_prod + 64'h0000_0000_8000_0000;
        n_s7_q = n_s7_pacc[63:32];
        n_s7_qs = RAW_W'($signed({1'b0, n_s7_q}));
        n_s7_uraw = r_s6_neg ? RAW_W'(r_s6_u) - n_s7_qs : RAW_W'(r_s6_u) + n_s7_qs;
        n_s7_usat = sat_value(n_s7_uraw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_r <= i_r_here;
        r_s1_l <= i_l_here;
        r_s1_s <= i_s_here;
        r_s1_u <= i_u_here;
        r_s1_dse <= n_s1_dse;
        r_s1_dsn <= n_s1_dsn;
        r_s1_r2 <= n_s1_r2;
        r_s1_l2 <= n_s1_l2;
        r_s1_hx <= n_s1_hx;
        r_s1_s2 <= n_s1_s2;

        r_s2_r <= r_s1_r;
        r_s2_l <= r_s1_l;
        r_s2_s <= r_s1_s;
        r_s2_u <= r_s1_u;
        r_s2_pr1 <= n_s2_pr1;
        r_s2_pl1 <= n_s2_pl1;
        r_s2_pr2 <= n_s2_pr2;
        r_s2_pl2 <= n_s2_pl2;
        r_s2_hx <= r_s1_hx;
        r_s2_ph <= n_s2_ph;

        r_s3_s <= r_s2_s;
        r_s3_u <= r_s2_u;
        r_s3_rraw <= n_s3_rraw;
        r_s3_lraw <= n_s3_lraw;
        r_s3_h <= n_s3_h;

        r_s4_s <= r_s3_s;
        r_s4_u <= r_s3_u;
        r_s4_rn <= n_s4_rsat.value;
        r_s4_ln <= n_s4_lsat.value;
        r_s4_clip <= n_s4_rsat.clip | n_s4_lsat.clip;
        r_s4_ch <= n_s4_ch;

        r_s5_u <= r_s4_u;
        r_s5_rn <= r_s4_rn;
        r_s5_ln <= r_s4_ln;
        r_s5_sn <= n_s5_ssat.value;
        r_s5_clip <= r_s4_clip | n_s5_ssat.clip;
        r_s5_neg <= n_s5_delta[32];
        r_s5_mag <= n_s5_abs[VALUE_W-1:0];

        r_s6_u <= r_s5_u;
        r_s6_rn <= r_s5_rn;
        r_s6_ln <= r_s5_ln;
        r_s6_sn <= r_s5_sn;
        r_s6_clip <= r_s5_clip;
        r_s6_neg <= r_s5_neg;
        r_s6_prod <= n_s6_prod;

        r_s7_rn <= r_s6_rn;
        r_s7_ln <= r_s6_ln;
        r_s7_sn <= r_s6_sn;
        r_s7_un <= n_s7_usat.value;
        r_s7_clip <= r_s6_clip | n_s7_usat.clip;
    end

    assign o_valid = r_s7_v;
    assign o_r_next = r_s7_rn;
    assign o_l_next = r_s7_ln;
    assign o_s_next = r_s7_sn;
    assign o_u_next = r_s7_un;
    assign o_saturated = r_s7_clip;

    // Every accepted transaction produces its result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_valid)
        else $error("result missing seven cycles after an accepted transaction");

    // A result strobe must come from an item that was in stage 6, the stage before the output registers.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_s6_v))
        else $error("result strobe without an item in the pipeline");

    // A clipped result shows at least one value at a range limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_r_next == VAL_MAX || o_r_next == VAL_MIN ||
             o_l_next == VAL_MAX || o_l_next == VAL_MIN ||
             o_s_next == VAL_MAX || o_s_next == VAL_MIN ||
             o_u_next == VAL_MAX || o_u_next == VAL_MIN))
        else $error("saturated flag set with no value at a range limit");

endmodule

// ===== bench/lwac_cell_checker.sv =====
module lwac_cell_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_r_here,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_r_east,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_r_west,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_l_here,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_l_north,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_l_south,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_s_here,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_s_east,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_s_west,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_s_north,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_s_south,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_u_here,
    input  logic                                 i_cfg_we,
    input  logic [lwac_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lwac_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_r_next,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_l_next,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_s_next,
    input  logic signed [lwac_pkg::VALUE_W-1:0]  i_u_next,
    input  logic                                 i_saturated,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_result_count,
    output int                                   o_clip_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import lwac_pkg::*;

    localparam longint COURANT_ONE = 65536;
    localparam longint VMAX = longint'(VAL_MAX);
    localparam longint VMIN = longint'(VAL_MIN);

    typedef struct packed {
        logic signed [VALUE_W-1:0] r_next;
        logic signed [VALUE_W-1:0] l_next;
        logic signed [VALUE_W-1:0] s_next;
        logic signed [VALUE_W-1:0] u_next;
        logic                      saturated;
    } t_cell_update;

    t_cell_update         expected_updates[$];
    logic [COURANT_W-1:0] courant_cfg = COURANT_RESET;
    logic [HALF_DT_W-1:0] half_dt_cfg = HALF_DT_RESET;
    int                   fail_total = 0;
    int                   result_total = 0;
    int                   clip_total = 0;

    // Floor of (x + 2^(k-1)) / 2^k, so exact halves go toward plus infinity.
    function automatic longint round_shift(input longint x, input int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clamp(input longint x);
        if (x > VMAX) begin
            return VMAX;
        end
        if (x < VMIN) begin
            return VMIN;
        end
        return x;
    endfunction

    function automatic t_cell_update predict_cell_update();
        longint c, d, r, re, rw, l, ln, ls, s, se, sw, sn, ss, u;
        longint r_raw, l_raw, s_raw, u_raw, h, delta;
        longint r_new, l_new, s_new, u_new;
        logic [63:0] mag, u_step;
        t_cell_update upd;
        c = longint'(courant_cfg);
        d = COURANT_ONE - c;
        r = longint'(i_r_here);
        re = longint'(i_r_east);
        rw = longint'(i_r_west);
        l = longint'(i_l_here);
        ln = longint'(i_l_north);
        ls = longint'(i_l_south);
        s = longint'(i_s_here);
        se = longint'(i_s_east);
        sw = longint'(i_s_west);
        sn = longint'(i_s_north);
        ss = longint'(i_s_south);
        u = longint'(i_u_here);

        r_raw = r + round_shift(c * (se - sw) + d * (re - 2 * r + rw), 17);
        l_raw = l + round_shift(c * (sn - ss) + d * (ln - 2 * l + ls), 17);
        h = round_shift(((re - rw) + (ln - ls)) * COURANT_ONE
                        + d * ((se - 2 * s + sw) + (sn - 2 * s + ss)), 17);
        s_raw = s + round_shift(c * h, 16);
        r_new = clamp(r_raw);
        l_new = clamp(l_raw);
        s_new = clamp(s_raw);

        // The field moves by the saturated change of s times the half time step, rounded half away from zero.
        delta = s_new - s;
        mag = (delta < 0) ? -delta : delta;
        u_step = (mag * {32'd0, half_dt_cfg} + 64'h8000_0000) >> 32;
        u_raw = (delta < 0) ? u - longint'(u_step) : u + longint'(u_step);
        u_new = clamp(u_raw);

        upd.r_next = r_new[VALUE_W-1:0];
        upd.l_next = l_new[VALUE_W-1:0];
        upd.s_next = s_new[VALUE_W-1:0];
        upd.u_next = u_new[VALUE_W-1:0];
        upd.saturated = (r_new != r_raw) || (l_new != l_raw)
                        || (s_new != s_raw) || (u_new != u_raw);
        return upd;
    endfunction

    task automatic check_field(input string label, input logic signed [VALUE_W-1:0] want,
                               input logic signed [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, label, want, want, got, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cell_update want;
        if (!i_rst_n) begin
            courant_cfg = COURANT_RESET;
            half_dt_cfg = HALF_DT_RESET;
            expected_updates.delete();
        end else begin
            if (i_valid) begin
                if (expected_updates.size() == 0) begin
                    $display("%0t: result transaction with no cell update outstanding", $time);
                    fail_total++;
                end else begin
                    want = expected_updates.pop_front();
                    check_field("r_next", want.r_next, i_r_next);
                    check_field("l_next", want.l_next, i_l_next);
                    check_field("s_next", want.s_next, i_s_next);
                    check_field("u_next", want.u_next, i_u_next);
                    check_field("saturated", VALUE_W'(want.saturated),
                                VALUE_W'(i_saturated));
                    result_total++;
                    if (want.saturated) begin
                        clip_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_updates.push_back(predict_cell_update());
            end
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_COURANT) begin
                    courant_cfg = i_cfg_data[COURANT_W-1:0];
                end else begin
                    half_dt_cfg = i_cfg_data[HALF_DT_W-1:0];
                end
            end
        end
        o_pending <= expected_updates.size();
        o_fail_count <= fail_total;
        o_result_count <= result_total;
        o_clip_count <= clip_total;
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lwac_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int LATENCY = 7;
    localparam int SETTINGS_COUNT = 11;
    localparam int CELLS_PER_SETTING = 160;
    localparam int DIRECTED_CELLS = 17;
    localparam int IDLE_PCT = 29;
    localparam int STALL_LIMIT = 4000;
    localparam int NBR_COUNT = 12;

    localparam int R_HERE = 0;
    localparam int R_EAST = 1;
    localparam int R_WEST = 2;
    localparam int L_HERE = 3;
    localparam int L_NORTH = 4;
    localparam int L_SOUTH = 5;
    localparam int S_HERE = 6;
    localparam int S_EAST = 7;
    localparam int S_WEST = 8;
    localparam int S_NORTH = 9;
    localparam int S_SOUTH = 10;
    localparam int U_HERE = 11;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [NBR_COUNT-1:0][VALUE_W-1:0]    nbr_bus = '0;
    logic                                 cfg_we = 1'b0;
    t_cfg_idx                             cfg_idx = CFG_COURANT;
    logic [CFG_DATA_W-1:0]                cfg_data = '0;
    logic                                 o_valid;
    logic signed [VALUE_W-1:0]            o_r_next;
    logic signed [VALUE_W-1:0]            o_l_next;
    logic signed [VALUE_W-1:0]            o_s_next;
    logic signed [VALUE_W-1:0]            o_u_next;
    logic                                 o_saturated;
    int                                   fail_count;
    int                                   pending;
    int                                   result_count;
    int                                   clip_count;

    logic [VALUE_W-1:0] nbr [NBR_COUNT];
    bit                 idle_on;
    int                 stall_cycles = 0;

    lax_wendroff_acoustic_cell_update_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_r_here    (nbr_bus[R_HERE]),
        .i_r_east    (nbr_bus[R_EAST]),
        .i_r_west    (nbr_bus[R_WEST]),
        .i_l_here    (nbr_bus[L_HERE]),
        .i_l_north   (nbr_bus[L_NORTH]),
        .i_l_south   (nbr_bus[L_SOUTH]),
        .i_s_here    (nbr_bus[S_HERE]),
        .i_s_east    (nbr_bus[S_EAST]),
        .i_s_west    (nbr_bus[S_WEST]),
        .i_s_north   (nbr_bus[S_NORTH]),
        .i_s_south   (nbr_bus[S_SOUTH]),
        .i_u_here    (nbr_bus[U_HERE]),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_valid     (o_valid),
        .o_r_next    (o_r_next),
        .o_l_next    (o_l_next),
        .o_s_next    (o_s_next),
        .o_u_next    (o_u_next),
        .o_saturated (o_saturated)
    );

    lwac_cell_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_r_here       (nbr_bus[R_HERE]),
        .i_r_east       (nbr_bus[R_EAST]),
        .i_r_west       (nbr_bus[R_WEST]),
        .i_l_here       (nbr_bus[L_HERE]),
        .i_l_north      (nbr_bus[L_NORTH]),
        .i_l_south      (nbr_bus[L_SOUTH]),
        .i_s_here       (nbr_bus[S_HERE]),
        .i_s_east       (nbr_bus[S_EAST]),
        .i_s_west       (nbr_bus[S_WEST]),
        .i_s_north      (nbr_bus[S_NORTH]),
        .i_s_south      (nbr_bus[S_SOUTH]),
        .i_u_here       (nbr_bus[U_HERE]),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (o_valid),
        .i_r_next       (o_r_next),
        .i_l_next       (o_l_next),
        .i_s_next       (o_s_next),
        .i_u_next       (o_u_next),
        .i_saturated    (o_saturated),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_clip_count   (clip_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [VALUE_W-1:0] scaled_value(input int sh);
        logic [VALUE_W-1:0] mask;
        mask = (32'd1 << (sh + 1)) - 32'd1;
        return ($urandom & mask) - (32'd1 << sh);
    endfunction

    function automatic logic [VALUE_W-1:0] edge_value();
        case ($urandom_range(5))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return VALUE_W'($urandom_range(4)) - VALUE_W'(2);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_random_cell();
        int mode;
        int sh;
        mode = $urandom_range(9);
        sh = $urandom_range(30, 4);
        for (int i = 0; i < NBR_COUNT; i++) begin
            if (mode < 6) begin
                nbr[i] = scaled_value(sh);
            end else if (mode < 9) begin
                nbr[i] = edge_value();
            end else begin
                nbr[i] = $urandom;
            end
        end
    endtask

    task automatic load_directed_cell(input int n);
        for (int i = 0; i < NBR_COUNT; i++) begin
            nbr[i] = '0;
        end
        case (n)
            1: for (int i = 0; i < NBR_COUNT; i++) nbr[i] = VAL_MAX;
            2: for (int i = 0; i < NBR_COUNT; i++) nbr[i] = VAL_MIN;
            3: begin
                nbr[R_HERE] = VAL_MAX;
                nbr[S_EAST] = VAL_MAX;
                nbr[S_WEST] = VAL_MIN;
            end
            4: begin
                nbr[R_HERE] = VAL_MIN;
                nbr[S_EAST] = VAL_MIN;
                nbr[S_WEST] = VAL_MAX;
            end
            5: begin
                nbr[L_HERE] = VAL_MAX;
                nbr[S_NORTH] = VAL_MAX;
                nbr[S_SOUTH] = VAL_MIN;
            end
            6: begin
                nbr[L_HERE] = VAL_MIN;
                nbr[S_NORTH] = VAL_MIN;
                nbr[S_SOUTH] = VAL_MAX;
            end
            7: begin
                nbr[S_HERE] = VAL_MAX;
                nbr[R_EAST] = VAL_MAX;
                nbr[R_WEST] = VAL_MIN;
                nbr[L_NORTH] = VAL_MAX;
                nbr[L_SOUTH] = VAL_MIN;
            end
            8: begin
                nbr[S_HERE] = VAL_MIN;
                nbr[R_EAST] = VAL_MIN;
                nbr[R_WEST] = VAL_MAX;
                nbr[L_NORTH] = VAL_MIN;
                nbr[L_SOUTH] = VAL_MAX;
            end
            9: begin
                nbr[U_HERE] = VAL_MAX;
                nbr[R_EAST] = 32'd2;
            end
            10: begin
                nbr[U_HERE] = VAL_MIN;
                nbr[R_WEST] = 32'd2;
            end
            11: nbr[S_EAST] = 32'd1;
            12: nbr[S_WEST] = 32'd1;
            13: nbr[S_NORTH] = 32'd1;
            14: begin
                nbr[U_HERE] = 32'd5;
                nbr[L_SOUTH] = 32'd2;
            end
            15: for (int i = 0; i < NBR_COUNT; i++) nbr[i] = 32'hAAAA_AAAA;
            16: for (int i = 0; i < NBR_COUNT; i++) nbr[i] = 32'h5555_5555;
            default: ;
        endcase
    endtask

    task automatic send_cell();
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        for (int i = 0; i < NBR_COUNT; i++) begin
            nbr_bus[i] <= nbr[i];
        end
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic program_setting(input int setting);
        logic [COURANT_W-1:0] courant;
        logic [HALF_DT_W-1:0] half_dt;
        logic [CFG_DATA_W-1:0] courant_word;
        case (setting)
            1: begin
                courant = 17'd65536;
                half_dt = 32'h8000_0000;
            end
            2: begin
                courant = '0;
                half_dt = 32'hFFFF_FFFF;
            end
            3: begin
                courant = 17'h1FFFF;
                half_dt = '0;
            end
            4: begin
                courant = 17'd1;
                half_dt = 32'd1;
            end
            default: begin
                if ($urandom_range(9) == 0) begin
                    courant = COURANT_W'($urandom_range(131071, 65537));
                end else begin
                    courant = COURANT_W'($urandom_range(65536));
                end
                half_dt = $urandom;
            end
        endcase
        courant_word = $urandom;
        courant_word[COURANT_W-1:0] = courant;
        cfg_we <= 1'b1;
        cfg_idx <= CFG_COURANT;
        cfg_data <= courant_word;
        @(posedge i_clk);
        cfg_idx <= CFG_HALF_DT;
        cfg_data <= half_dt;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int setting = 0; setting < SETTINGS_COUNT; setting++) begin
            if (setting > 0) begin
                drain();
                program_setting(setting);
            end
            idle_on = (setting != 2);
            if (setting == 1) begin
                for (int n = 0; n < DIRECTED_CELLS; n++) begin
                    load_directed_cell(n);
                    send_cell();
                end
            end
            for (int k = 0; k < CELLS_PER_SETTING; k++) begin
                load_random_cell();
                send_cell();
            end
        end
        drain();
        repeat (LATENCY + 3) @(posedge i_clk);
        $display("Checked %0d cell updates over %0d register settings,", result_count,
                 SETTINGS_COUNT);
        $display("including Courant zero, one and above one; %0d results clipped.", clip_count);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
